// ===== design/ppc_pkg.sv =====
package ppc_pkg;

    localparam int MAX_SPRITES_DEF = 8;
    localparam int PALETTE_ENTRIES = 32;
    localparam int PAL_ADDR_W      = 5;
    localparam int COLOUR_W        = 6;
    localparam int SPRITE_W        = 28;
    localparam int CFG_IDX_W       = 3;
    localparam int BG_TOP_BIT      = 15;
    localparam int LAST_ROW        = 239;
    localparam int LAST_COL        = 255;

    typedef enum logic [2:0] {
        FN_RENDER      = 3'd0,
        FN_LOAD_SPRITE = 3'd1,
        FN_SET_COUNT   = 3'd2,
        FN_PAL_WRITE   = 3'd3,
        FN_CLEAR_HIT   = 3'd4
    } ppc_func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHOW_BG       = 3'd0,
        CFG_SHOW_BG_LEFT  = 3'd1,
        CFG_SHOW_SPR      = 3'd2,
        CFG_SHOW_SPR_LEFT = 3'd3
    } ppc_cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PAL_REQ,
        ST_PAL_DATA
    } ppc_state_t;

    typedef struct packed {
        logic                  en;
        logic [PAL_ADDR_W-1:0] addr;
        logic [COLOUR_W-1:0]   data;
    } ppc_pal_wr_t;

    // palette contents after reset
    function automatic logic [COLOUR_W-1:0] ppc_startup(input logic [PAL_ADDR_W-1:0] idx);
        logic [COLOUR_W-1:0] v;
        case (idx)
            5'd0:    v = 6'h09;
            5'd1:    v = 6'h01;
            5'd2:    v = 6'h00;
            5'd3:    v = 6'h01;
            5'd4:    v = 6'h00;
            5'd5:    v = 6'h02;
            5'd6:    v = 6'h02;
            5'd7:    v = 6'h0D;
            5'd8:    v = 6'h08;
            5'd9:    v = 6'h10;
            5'd10:   v = 6'h08;
            5'd11:   v = 6'h24;
            5'd12:   v = 6'h00;
            5'd13:   v = 6'h00;
            5'd14:   v = 6'h04;
            5'd15:   v = 6'h2C;
            5'd16:   v = 6'h09;
            5'd17:   v = 6'h01;
            5'd18:   v = 6'h34;
            5'd19:   v = 6'h03;
            5'd20:   v = 6'h00;
            5'd21:   v = 6'h04;
            5'd22:   v = 6'h00;
            5'd23:   v = 6'h14;
            5'd24:   v = 6'h08;
            5'd25:   v = 6'h3A;
            5'd26:   v = 6'h00;
            5'd27:   v = 6'h02;
            5'd28:   v = 6'h00;
            5'd29:   v = 6'h20;
            5'd30:   v = 6'h2C;
            5'd31:   v = 6'h08;
            default: v = 6'h00;
        endcase
        return v;
    endfunction

endpackage

// ===== design/ppu_pixel_compositor.sv =====
// Pixel compositor: each render word gives one pixel (palette index, column, row and the
// sticky sprite-zero hit); load-slot, set-count, palette-write and clear-hit words give no
// output word and do not stall the input. A render word stalls the input while the sprite
// slot memory is read one slot per cycle over the active sprites (only when sprites show at
// that column), then while the palette memory is read through its registered read port and
// the result waits to be loaded. The result sits in an output register, so the next
// word is accepted while it waits to be taken; a second render result waits for the first.
// Among covering opaque sprites the lowest slot that is in front, or over a transparent
// background, picks the colour. Palette entries read their startup value until written.
// Configuration writes are always ready and must only be issued while the block is idle.
module ppu_pixel_compositor #(
    parameter int MAX_SPRITES = ppc_pkg::MAX_SPRITES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ppc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                          cfg_data,
    // input word channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    func,
    input  logic [4:0]                    target_index,
    input  logic [27:0]                   payload,
    input  logic [7:0]                    pixel_x,
    input  logic [7:0]                    pixel_y,
    input  logic [2:0]                    fine_x,
    input  logic [15:0]                   bg_pattern_low,
    input  logic [15:0]                   bg_pattern_high,
    input  logic [3:0]                    attr_old,
    input  logic [3:0]                    attr_new,
    // output word channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [5:0]                    colour_index,
    output logic [7:0]                    out_x,
    output logic [7:0]                    out_y,
    output logic                          zero_hit
);
    import ppc_pkg::*;

    localparam int SLOT_W = (MAX_SPRITES > 1) ? $clog2(MAX_SPRITES) : 1;
    localparam int CNT_W  = $clog2(MAX_SPRITES + 1);

    // configuration
    logic show_bg_reg, show_bg_left_reg, show_spr_reg, show_spr_left_reg;

    // control state
    ppc_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              hit_reg, hit_next;
    logic              out_valid_reg, out_valid_next;

    // per-pixel working registers
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [3:0]        bgc_reg, bgc_next;
    logic              win_reg, win_next;
    logic [3:0]        win_col_reg, win_col_next;
    logic [7:0]        px_reg, py_reg;

    // output payload
    logic [5:0]        colour_reg;
    logic [7:0]        x_reg, y_reg;
    logic              hit_out_reg;
    logic              load_out;

    logic              accept;
    logic              cfg_write;

    // memory ports
    ppc_pal_wr_t           pal_wr;
    logic                  pal_rd_en;
    logic [PAL_ADDR_W-1:0] pal_rd_addr;
    logic [COLOUR_W-1:0]   pal_rd_data;
    logic                  spr_wr_en;
    logic                  spr_rd_en;
    logic [SLOT_W-1:0]     spr_rd_addr;
    logic [SPRITE_W-1:0]   spr_rd_data;

    // background pixel from the shifters
    logic [3:0] bg_sum, bg_off;
    logic [1:0] bg_pat;
    logic [3:0] bg_colour;
    logic       bg_en, spr_en, left_col;

    // sprite slot evaluation
    logic [8:0] spr_diff;
    logic [2:0] spr_rel;
    logic [2:0] spr_bit;
    logic [1:0] spr_pat;
    logic       spr_cover, spr_opaque, last_slot;

    assign accept    = in_valid && !in_stall;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);

    assign left_col  = (pixel_x < 8'd8);
    assign bg_en     = show_bg_reg && !(left_col && !show_bg_left_reg);
    // sprites never cover the last column
    assign spr_en    = show_spr_reg && !(left_col && !show_spr_left_reg)
                       && (pixel_x != 8'(LAST_COL)) && (cnt_reg != '0);

    assign bg_sum    = {1'b0, fine_x} + {1'b0, pixel_x[2:0]};
    assign bg_off    = 4'(BG_TOP_BIT) - bg_sum;
    assign bg_pat    = {bg_pattern_high[bg_off], bg_pattern_low[bg_off]};
    assign bg_colour = (!bg_en || bg_pat == 2'b00) ? 4'd0
                     : ((bg_off[3] ? attr_old : attr_new) | {2'b00, bg_pat});

    // sprite record: x[7:0], pattern low[15:8], pattern high[23:16], palette[25:24],
    // front[26], sprite zero[27]
    assign spr_diff   = {1'b0, px_reg} - {1'b0, spr_rd_data[7:0]};
    assign spr_cover  = (spr_diff[8:3] == 6'd0);
    assign spr_rel    = spr_diff[2:0];
    // leftmost sprite pixel sits in the top bit of each pattern byte
    assign spr_bit    = ~spr_rel;
    assign spr_pat    = {spr_rd_data[16 + int'(spr_bit)], spr_rd_data[8 + int'(spr_bit)]};
    assign spr_opaque = spr_cover && (spr_pat != 2'b00);
    assign last_slot  = ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);

    assign load_out   = (state_reg == ST_PAL_DATA) && (!out_valid_reg || !out_stall);

    // memory hookup
    assign pal_wr.en   = accept && (func == FN_PAL_WRITE);
    assign pal_wr.addr = target_index;
    assign pal_wr.data = payload[5:0];
    assign pal_rd_en   = (state_reg == ST_PAL_REQ);
    // sprite colors live in the upper half of the palette
    assign pal_rd_addr = win_reg ? {1'b1, win_col_reg} : {1'b0, bgc_reg};

    assign spr_wr_en   = accept && (func == FN_LOAD_SPRITE)
                         && (32'(target_index) < MAX_SPRITES);
    assign spr_rd_addr = (state_reg == ST_IDLE) ? '0 : SLOT_W'(idx_reg + SLOT_W'(1));
    assign spr_rd_en   = ((state_reg == ST_IDLE) && accept && (func == FN_RENDER) && spr_en)
                         || ((state_reg == ST_SCAN) && !last_slot);

    ppc_palette_ram u_palette (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (pal_wr),
        .rd_en   (pal_rd_en),
        .rd_addr (pal_rd_addr),
        .rd_data (pal_rd_data)
    );

    ppc_sprite_ram #(
        .DEPTH  (MAX_SPRITES),
        .ADDR_W (SLOT_W)
    ) u_sprites (
        .clk     (clk),
        .wr_en   (spr_wr_en),
        .wr_addr (SLOT_W'(target_index)),
        .wr_data (payload),
        .rd_en   (spr_rd_en),
        .rd_addr (spr_rd_addr),
        .rd_data (spr_rd_data)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            show_bg_reg       <= 1'b0;
            show_bg_left_reg  <= 1'b0;
            show_spr_reg      <= 1'b0;
            show_spr_left_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SHOW_BG:       show_bg_reg       <= cfg_data;
                CFG_SHOW_BG_LEFT:  show_bg_left_reg  <= cfg_data;
                CFG_SHOW_SPR:      show_spr_reg      <= cfg_data;
                CFG_SHOW_SPR_LEFT: show_spr_left_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and output payload registers
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        bgc_reg     <= bgc_next;
        win_reg     <= win_next;
        win_col_reg <= win_col_next;
        if (accept && func == FN_RENDER)
        begin
            px_reg <= pixel_x;
            py_reg <= pixel_y;
        end
        if (load_out)
        begin
            colour_reg  <= pal_rd_data;
            x_reg       <= px_reg;
            y_reg       <= py_reg;
            hit_out_reg <= hit_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        hit_next       = hit_reg;
        idx_next       = idx_reg;
        bgc_next       = bgc_reg;
        win_next       = win_reg;
        win_col_next   = win_col_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        FN_RENDER:
                        begin
                            bgc_next   = bg_colour;
                            win_next   = 1'b0;
                            idx_next   = '0;
                            state_next = spr_en ? ST_SCAN : ST_PAL_REQ;
                        end
                        FN_SET_COUNT:
                        begin
                            cnt_next = (32'(target_index) > MAX_SPRITES)
                                     ? CNT_W'(MAX_SPRITES) : CNT_W'(target_index);
                        end
                        FN_CLEAR_HIT:
                        begin
                            hit_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                // one slot per cycle, lowest slot first
                if (spr_opaque)
                begin
                    if (spr_rd_data[27] && bgc_reg != 4'd0 && py_reg <= 8'(LAST_ROW))
                    begin
                        hit_next = 1'b1;
                    end
                    if (!win_reg && (spr_rd_data[26] || bgc_reg == 4'd0))
                    begin
                        win_next     = 1'b1;
                        win_col_next = {spr_rd_data[25:24], spr_pat};
                    end
                end
                idx_next = SLOT_W'(idx_reg + SLOT_W'(1));
                if (last_slot)
                begin
                    state_next = ST_PAL_REQ;
                end
            end
            ST_PAL_REQ:
            begin
                state_next = ST_PAL_DATA;
            end
            ST_PAL_DATA:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign colour_index = colour_reg;
    assign out_x        = x_reg;
    assign out_y        = y_reg;
    assign zero_hit     = hit_out_reg;

endmodule

// ===== design/ppc_palette_ram.sv =====
module ppc_palette_ram (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ppc_pkg::ppc_pal_wr_t         wr,
    input  logic                         rd_en,
    input  logic [ppc_pkg::PAL_ADDR_W-1:0] rd_addr,
    output logic [ppc_pkg::COLOUR_W-1:0]   rd_data
);
    import ppc_pkg::*;

    logic [COLOUR_W-1:0]        mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] valid_reg;
    logic [COLOUR_W-1:0]        data_reg;
    logic                       hit_valid_reg;
    logic [PAL_ADDR_W-1:0]      addr_reg;

    // written entries tracked per entry, unwritten ones read the startup value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            data_reg      <= mem[rd_addr];
            hit_valid_reg <= valid_reg[rd_addr];
            addr_reg      <= rd_addr;
        end
    end

    assign rd_data = hit_valid_reg ? data_reg : ppc_startup(addr_reg);

endmodule

// ===== design/ppc_sprite_ram.sv =====
module ppc_sprite_ram #(
    parameter int DEPTH  = ppc_pkg::MAX_SPRITES_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [ppc_pkg::SPRITE_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic [ppc_pkg::SPRITE_W-1:0] rd_data
);
    import ppc_pkg::*;

    logic [SPRITE_W-1:0] mem [DEPTH];
    logic [SPRITE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/ppc_checker.sv =====
module ppc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [2:0]                    func,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [5:0]                    colour_index,
    input logic [7:0]                    out_x,
    input logic [7:0]                    out_y,
    input logic                          zero_hit
);
    import ppc_pkg::*;

    // a render word keeps the input side busy in the cycle after it is taken
    a_render_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && func == FN_RENDER |=> in_stall)
        else $error("input taken right after a render word");

    // other words leave the input free in the cycle after they are taken
    a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && func != FN_RENDER |=> !in_stall)
        else $error("non-render word held the input");

    // a new output word only appears at the end of render work
    a_out_from_render: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("output word without render work");

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(colour_index)
                                   && $stable(out_x) && $stable(out_y) && $stable(zero_hit))
        else $error("stalled output word changed");

endmodule

bind ppu_pixel_compositor ppc_checker u_ppc_checker (.*);
